// ----- hdl/b64e_pkg.sv -----
package b64e_pkg;

	// Position of a byte within its 3-byte group
	typedef enum logic [2:0] {
		PH_FIRST  = 3'b001,
		PH_SECOND = 3'b010,
		PH_THIRD  = 3'b100
	} phase_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       end_of_message;
	} byte_item_t;

	typedef struct packed {
		logic [6:0] out_char;
		logic       last_of_run;
	} char_item_t;

	// Registered request handed from the input stage to the output buffer
	typedef struct packed {
		logic [7:0] data_byte;
		logic       eom;
		phase_t     phase;
		logic [3:0] carry;
	} enc_req_t;

	typedef struct packed {
		logic [5:0] sextet0;
		logic [5:0] sextet1;
		logic       two;
	} enc_pair_t;

	localparam logic [6:0] ASC_UPPER_A = 7'd65;
	localparam logic [6:0] ASC_LOWER_A = 7'd97;
	localparam logic [6:0] ASC_DIGIT_0 = 7'd48;
	localparam logic [6:0] ASC_PLUS    = 7'd43;
	localparam logic [6:0] ASC_SLASH   = 7'd47;

	function automatic logic [6:0] sextet_to_ascii(input logic [5:0] s);
		logic [6:0] s7;
		s7 = {1'b0, s};
		if (s < 6'd26)
			return ASC_UPPER_A + s7;
		else if (s < 6'd52)
			return ASC_LOWER_A + s7 - 7'd26;
		else if (s < 6'd62)
			return ASC_DIGIT_0 + s7 - 7'd52;
		else if (s == 6'd62)
			return ASC_PLUS;
		else
			return ASC_SLASH;
	endfunction

	function automatic enc_pair_t encode(input enc_req_t r);
		enc_pair_t p;
		unique case (r.phase)
			PH_SECOND: begin
				p.sextet0 = {r.carry[1:0], r.data_byte[7:4]};
				p.sextet1 = {r.data_byte[3:0], 2'b00};
				p.two     = r.eom;
			end
			PH_THIRD: begin
				p.sextet0 = {r.carry, r.data_byte[7:6]};
				p.sextet1 = r.data_byte[5:0];
				p.two     = 1'b1;
			end
			default: begin
				p.sextet0 = r.data_byte[7:2];
				p.sextet1 = {r.data_byte[1:0], 4'b0000};
				p.two     = r.eom;
			end
		endcase
		return p;
	endfunction

endpackage

// ----- hdl/b64e_byte_if.sv -----
interface b64e_byte_if;
	import b64e_pkg::*;

	logic       valid;
	logic       ready;
	byte_item_t payload;

	modport source(output valid, output payload, input ready);
	modport sink(input valid, input payload, output ready);
endinterface

// ----- hdl/b64e_char_if.sv -----
interface b64e_char_if;
	import b64e_pkg::*;

	logic       valid;
	logic       ready;
	char_item_t payload;

	modport source(output valid, output payload, input ready);
	modport sink(input valid, input payload, output ready);
endinterface

// ----- hdl/base64_byte_encoder_unit.sv -----
// Streaming base64 encoder (standard alphabet, no '=' padding). Bytes enter on msg with
// end_of_message on the final byte; ASCII characters leave on chars, last_of_run marking the
// final character caused by each byte. A byte is taken every cycle while it yields one
// character and chars is ready; a byte that yields two (third byte of a group, or a last
// byte in the first or second group position) occupies the output until both leave, as the
// two-entry output buffer drains one character per cycle while chars is ready. An accepted
// byte passes the input register, then the output buffer, before its first character shows
// valid. The buffer refills in the cycle its last character leaves, so single-character
// bytes stream at one per cycle unless stalled, when the input register holds one more byte.
module base64_byte_encoder_unit (
	input logic         clk,
	input logic         arst_n,
	b64e_byte_if.sink   msg,
	b64e_char_if.source chars
);
	import b64e_pkg::*;

	enc_req_t req;
	logic     req_valid;
	logic     req_ready;

	b64e_in_stage u_in_stage (
		.clk       (clk),
		.arst_n    (arst_n),
		.msg       (msg),
		.req       (req),
		.req_valid (req_valid),
		.req_ready (req_ready)
	);

	b64e_out_buffer u_out_buffer (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.chars     (chars)
	);

endmodule

// ----- hdl/b64e_in_stage.sv -----
module b64e_in_stage (
	input  logic               clk,
	input  logic               arst_n,
	b64e_byte_if.sink          msg,
	output b64e_pkg::enc_req_t req,
	output logic               req_valid,
	input  logic               req_ready
);
	import b64e_pkg::*;

	phase_t     phase_q;
	logic [3:0] carry_q;
	logic       valid_s1;
	enc_req_t   req_s1;
	logic       accept;

	assign msg.ready = !valid_s1 || req_ready;
	assign accept    = msg.valid && msg.ready;
	assign req       = req_s1;
	assign req_valid = valid_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_FIRST;
			carry_q  <= 4'd0;
			valid_s1 <= 1'b0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
				if (msg.payload.end_of_message) begin
					phase_q <= PH_FIRST;
					carry_q <= 4'd0;
				end else begin
					unique case (phase_q)
						PH_SECOND: begin
							phase_q <= PH_THIRD;
							carry_q <= msg.payload.data_byte[3:0];
						end
						PH_THIRD: begin
							phase_q <= PH_FIRST;
							carry_q <= 4'd0;
						end
						default: begin
							phase_q <= PH_SECOND;
							carry_q <= {2'b00, msg.payload.data_byte[1:0]};
						end
					endcase
				end
			end else if (req_ready) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_s1.data_byte <= msg.payload.data_byte;
			req_s1.eom       <= msg.payload.end_of_message;
			req_s1.phase     <= phase_q;
			req_s1.carry     <= carry_q;
		end
	end

	a_eom_resets_group: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && msg.payload.end_of_message) |=> (phase_q == PH_FIRST && carry_q == 4'd0))
		else $error("group state not cleared after last byte");

	a_first_no_carry: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_FIRST) |-> (carry_q == 4'd0))
		else $error("carry bits left at group start");

	a_stall_holds_req: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !req_ready) |=> (valid_s1 && req_s1 == $past(req_s1)))
		else $error("pending request lost while stalled");

endmodule

// ----- hdl/b64e_out_buffer.sv -----
module b64e_out_buffer (
	input  logic               clk,
	input  logic               arst_n,
	input  b64e_pkg::enc_req_t req,
	input  logic               req_valid,
	output logic               req_ready,
	b64e_char_if.source        chars
);
	import b64e_pkg::*;

	logic [1:0] cnt_q;
	logic [6:0] char0_q;
	logic [6:0] char1_q;
	logic       last0_q;
	logic       last1_q;
	enc_pair_t  pair;
	logic       take;
	logic       load;

	assign pair      = encode(req);
	assign take      = chars.valid && chars.ready;
	// free when empty, or when the single held char leaves this cycle
	assign req_ready = (cnt_q == 2'd0) || (cnt_q == 2'd1 && chars.ready);
	assign load      = req_valid && req_ready;

	assign chars.valid               = (cnt_q != 2'd0);
	assign chars.payload.out_char    = char0_q;
	assign chars.payload.last_of_run = last0_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else begin
			if (load)
				cnt_q <= pair.two ? 2'd2 : 2'd1;
			else if (take)
				cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			char0_q <= sextet_to_ascii(pair.sextet0);
			char1_q <= sextet_to_ascii(pair.sextet1);
			last0_q <= !pair.two;
			last1_q <= 1'b1;
		end else if (take) begin
			char0_q <= char1_q;
			last0_q <= last1_q;
		end
	end

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != 2'd3)
		else $error("output buffer count out of range");

	a_pair_flags: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == 2'd2) |-> (!last0_q && last1_q))
		else $error("run-end flags wrong on held pair");

	a_shift_second: assert property (@(posedge clk) disable iff (!arst_n)
		(take && cnt_q == 2'd2) |=> (cnt_q == 2'd1 && char0_q == $past(char1_q) && last0_q))
		else $error("second char not advanced");

endmodule

// ----- bench/base64_byte_encoder_unit_tb.sv -----
`timescale 1ns / 100ps

module base64_byte_encoder_unit_tb;
	import b64e_pkg::*;

	localparam int STALL_LIMIT = 1000;
	localparam int ITEMS_PER_PASS = 135;
	localparam int DRAIN_CYCLES = 8;
	localparam int N_DIRECTED = 25;

	typedef struct packed {
		logic [7:0] data;
		logic       eom;
		logic       typed;
		logic [1:0] count;
		logic [7:0] c0;
		logic       l0;
		logic [7:0] c1;
		logic       l1;
	} dir_row_t;

	// typed rows carry the characters that are obvious by inspection
	localparam dir_row_t DIRECTED [N_DIRECTED] = '{
		'{8'h00, 1, 1, 2, "A", 0, "A", 1},
		'{8'hFF, 1, 1, 2, "/", 0, "w", 1},
		'{8'hFF, 0, 1, 1, "/", 1, 0, 0},
		'{8'hFF, 0, 1, 1, "/", 1, 0, 0},
		'{8'hFF, 1, 1, 2, "/", 0, "/", 1},
		'{8'h00, 0, 1, 1, "A", 1, 0, 0},
		'{8'h00, 0, 1, 1, "A", 1, 0, 0},
		'{8'h00, 1, 1, 2, "A", 0, "A", 1},
		'{8'h4D, 0, 0, 0, 0, 0, 0, 0},
		'{8'h61, 0, 0, 0, 0, 0, 0, 0},
		'{8'h6E, 0, 0, 0, 0, 0, 0, 0},
		'{8'h4D, 0, 0, 0, 0, 0, 0, 0},
		'{8'h61, 1, 0, 0, 0, 0, 0, 0},
		'{8'h80, 1, 0, 0, 0, 0, 0, 0},
		'{8'h01, 1, 0, 0, 0, 0, 0, 0},
		'{8'hFF, 0, 1, 1, "/", 1, 0, 0},
		'{8'h00, 1, 1, 2, "w", 0, "A", 1},
		'{8'h00, 0, 1, 1, "A", 1, 0, 0},
		'{8'hFF, 1, 1, 2, "P", 0, "8", 1},
		'{8'h00, 0, 0, 0, 0, 0, 0, 0},
		'{8'h00, 0, 0, 0, 0, 0, 0, 0},
		'{8'hFF, 1, 0, 0, 0, 0, 0, 0},
		'{8'hAA, 0, 0, 0, 0, 0, 0, 0},
		'{8'h55, 0, 0, 0, 0, 0, 0, 0},
		'{8'hF0, 1, 0, 0, 0, 0, 0, 0}
	};

	logic clk;
	logic arst_n;

	b64e_byte_if msg_if ();
	b64e_char_if chars_if ();

	base64_byte_encoder_unit uut (
		.clk   (clk),
		.arst_n(arst_n),
		.msg   (msg_if),
		.chars (chars_if)
	);

	string b64_alphabet = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

	// predictor state
	int unsigned group_pos;
	logic [3:0]  carry_nibble;

	char_item_t expected_chars [$];
	int         errors;
	int         stall_cycles;
	int         tx_idle_pct;
	int         rx_idle_pct;

	// typed expectation travelling with the request on the bus
	logic             row_typed;
	logic [1:0]       row_count;
	char_item_t [1:0] row_chars;

	function automatic logic [6:0] b64_char(input logic [5:0] sextet);
		byte c;
		c = b64_alphabet[sextet];
		return c[6:0];
	endfunction

	function automatic int encode_byte(input logic [7:0] d, input logic eom,
			output char_item_t [1:0] res);
		int n;
		n = 0;
		res = '0;
		case (group_pos)
			1: begin
				res[0] = '{b64_char({carry_nibble[1:0], d[7:4]}), !eom};
				n = 1;
				if (eom) begin
					res[1] = '{b64_char({d[3:0], 2'b00}), 1'b1};
					n = 2;
				end
				group_pos = 2;
				carry_nibble = d[3:0];
			end
			2: begin
				res[0] = '{b64_char({carry_nibble, d[7:6]}), 1'b0};
				res[1] = '{b64_char(d[5:0]), 1'b1};
				n = 2;
				group_pos = 0;
				carry_nibble = '0;
			end
			default: begin
				res[0] = '{b64_char(d[7:2]), !eom};
				n = 1;
				if (eom) begin
					res[1] = '{b64_char({d[1:0], 4'b0000}), 1'b1};
					n = 2;
				end
				group_pos = 1;
				carry_nibble = {2'b00, d[1:0]};
			end
		endcase
		if (eom) begin
			group_pos = 0;
			carry_nibble = '0;
		end
		return n;
	endfunction

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(negedge clk)
		chars_if.ready <= ($urandom_range(0, 99) >= rx_idle_pct);

	always @(posedge clk) begin
		char_item_t       got;
		char_item_t       want;
		char_item_t [1:0] pred;
		int               n;
		if (arst_n) begin
			if (chars_if.valid && chars_if.ready) begin
				got = chars_if.payload;
				if (expected_chars.size() == 0) begin
					$display("%0t: unexpected char: expected none, actual %h/%b",
						$time, got.out_char, got.last_of_run);
					errors++;
				end else begin
					want = expected_chars.pop_front();
					if (got.out_char !== want.out_char) begin
						$display("%0t: out_char mismatch: expected %h, actual %h",
							$time, want.out_char, got.out_char);
						errors++;
					end
					if (got.last_of_run !== want.last_of_run) begin
						$display("%0t: last_of_run mismatch: expected %b, actual %b",
							$time, want.last_of_run, got.last_of_run);
						errors++;
					end
				end
			end
			if (msg_if.valid && msg_if.ready) begin
				n = encode_byte(msg_if.payload.data_byte, msg_if.payload.end_of_message, pred);
				if (row_typed) begin
					pred = row_chars;
					n = row_count;
				end
				for (int i = 0; i < n; i++)
					expected_chars.push_back(pred[i]);
			end
			if ((chars_if.valid && chars_if.ready) || (msg_if.valid && msg_if.ready))
				stall_cycles = 0;
			else
				stall_cycles++;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("base64_byte_encoder_unit regression: fail");
				$finish;
			end
		end
	end

	task automatic send_byte(input logic [7:0] d, input logic eom, input logic typed,
			input logic [1:0] count, input char_item_t [1:0] chars);
		while ($urandom_range(0, 99) < tx_idle_pct) begin
			msg_if.valid <= 1'b0;
			@(negedge clk);
		end
		msg_if.valid <= 1'b1;
		msg_if.payload <= '{d, eom};
		row_typed <= typed;
		row_count <= count;
		row_chars <= chars;
		@(posedge clk);
		while (!msg_if.ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic send_message(input int len);
		logic [7:0] d;
		for (int k = 0; k < len; k++) begin
			case ($urandom_range(0, 7))
				0: d = 8'h00;
				1: d = 8'hFF;
				default: d = 8'($urandom_range(0, 255));
			endcase
			send_byte(d, k == len - 1, 1'b0, 2'd0, '0);
		end
	endtask

	initial begin
		int       sent;
		dir_row_t r;
		int       len;
		arst_n = 1'b0;
		msg_if.valid = 1'b0;
		msg_if.payload = '0;
		chars_if.ready = 1'b0;
		row_typed = 1'b0;
		row_count = '0;
		row_chars = '0;
		group_pos = 0;
		carry_nibble = '0;
		errors = 0;
		stall_cycles = 0;
		tx_idle_pct = 34;
		rx_idle_pct = 66;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		for (int i = 0; i < N_DIRECTED; i++) begin
			r = DIRECTED[i];
			send_byte(r.data, r.eom, r.typed, r.count,
				{char_item_t'{r.c1[6:0], r.l1}, char_item_t'{r.c0[6:0], r.l0}});
		end

		for (int pass = 0; pass < 3; pass++) begin
			case (pass)
				0: begin
					tx_idle_pct = 34;
					rx_idle_pct = 66;
				end
				1: begin
					tx_idle_pct = 66;
					rx_idle_pct = 34;
				end
				default: begin
					tx_idle_pct = 0;
					rx_idle_pct = 0;
				end
			endcase
			sent = 0;
			while (sent < ITEMS_PER_PASS) begin
				len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 30) : $urandom_range(1, 12);
				send_message(len);
				sent += len;
			end
		end

		msg_if.valid <= 1'b0;
		rx_idle_pct = 0;
		while (expected_chars.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("base64_byte_encoder_unit regression: pass");
		else
			$display("base64_byte_encoder_unit regression: fail");
		$finish;
	end

endmodule
